@@ hdl/mcsps_pkg.sv @@
// ----------------------------------------------------------------------------
// mcsps_pkg : servo pulse sequencer shared definitions
// Request types, action codes and reset constants of the servo sequencer.
// ----------------------------------------------------------------------------
package mcsps_pkg;

	localparam int DEF_CHANNELS   = 8;
	localparam int DEF_COUNT_BITS = 16;

	localparam int ACTION_W  = 2;
	localparam int CHANNEL_W = 3;
	localparam int PW_W      = 16;
	localparam int PINS_W    = 8;
	localparam int FRAME_W   = 16;

	localparam logic [FRAME_W-1:0] RESET_FRAME = FRAME_W'(18432);
	localparam logic [PW_W-1:0]    RESET_WIDTH = PW_W'(1500);

	localparam logic [ACTION_W-1:0] ACT_TICK      = 2'd0;
	localparam logic [ACTION_W-1:0] ACT_WRITE_ONE = 2'd1;
	localparam logic [ACTION_W-1:0] ACT_WRITE_ALL = 2'd2;
	localparam logic [ACTION_W-1:0] ACT_NONE      = 2'd3;

	typedef struct packed {
		logic [ACTION_W-1:0]  action;
		logic [CHANNEL_W-1:0] channel;
		logic [PW_W-1:0]      pulse_width;
	} in_item_t;

	typedef struct packed {
		logic [PINS_W-1:0] servo_pins;
		logic              frame_start;
		logic              overrun;
	} out_item_t;

endpackage

@@ hdl/multi_channel_servo_pulse_sequencer.sv @@
// ----------------------------------------------------------------------------
// multi_channel_servo_pulse_sequencer : servo frame generator, one slot per channel
// Steps channel slots and a rest slot on tick requests; width writes update
// a rotating width table and the running width sum.
// ----------------------------------------------------------------------------
// channel | signals                          | moves
// in      | in_valid  in_ready  in_data      | tick / width write request
// out     | out_valid out_ready out_data     | pins, frame start, overrun
// cfg     | cfg_valid cfg_ready cfg_data     | frame length
//
// One request per cycle while in_ready is high; its result is registered in the
// output register, or in the skid entry while the sink stalls. A two-entry output
// buffer lets requests through a stall; in_ready drops only when both entries hold results.
// Reset loads 1500 into every width and 18432 as frame length; the first
// tick starts slot 0. cfg_ready is always high.
// ----------------------------------------------------------------------------
module multi_channel_servo_pulse_sequencer #(
	parameter int CHANNELS   = mcsps_pkg::DEF_CHANNELS,
	parameter int COUNT_BITS = mcsps_pkg::DEF_COUNT_BITS
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	output logic                               in_ready,
	input  mcsps_pkg::in_item_t                in_data,
	output logic                               out_valid,
	input  logic                               out_ready,
	output mcsps_pkg::out_item_t               out_data,
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [mcsps_pkg::FRAME_W-1:0]      cfg_data
);
	import mcsps_pkg::*;

	localparam int SLOT_W = $clog2(CHANNELS + 1);
	localparam int IDX_W  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
	localparam int DIFF_W = IDX_W + 1;
	localparam int SUM_W  = PW_W + $clog2(CHANNELS + 1);

	logic [FRAME_W-1:0]    frame_q;
	logic [PW_W-1:0]       rot_q [CHANNELS];
	logic [PW_W-1:0]       rot_d [CHANNELS];
	logic [IDX_W-1:0]      ptr_q, ptr_d;
	logic [SUM_W-1:0]      sum_q, sum_d;
	logic [SLOT_W-1:0]     slot_q, slot_d, nslot;
	logic [COUNT_BITS-1:0] ticks_q, ticks_d, cnt_load;

	logic                  acc;
	logic                  tick, load, start, sat, wr_ok;
	logic [PW_W-1:0]       len16;
	logic [DIFF_W-1:0]     diff;
	logic [IDX_W-1:0]      phys;
	out_item_t             res;
	logic                  res_ready;

	assign cfg_ready = 1'b1;
	assign in_ready  = res_ready;
	assign acc       = in_valid && res_ready;

	always_comb begin
		tick  = acc && (in_data.action == ACT_TICK);
		load  = tick && (ticks_q == '0);
		nslot = (slot_q >= SLOT_W'(CHANNELS)) ? '0 : slot_q + SLOT_W'(1);

		if (nslot < SLOT_W'(CHANNELS)) begin
			len16 = (rot_q[0] == '0) ? PW_W'(1) : rot_q[0];
		end else if (sum_q >= SUM_W'(frame_q)) begin
			len16 = PW_W'(1);
		end else begin
			len16 = frame_q - PW_W'(sum_q);
		end
		sat      = (len16 >> COUNT_BITS) != '0;
		cnt_load = sat ? '1 : COUNT_BITS'(len16);

		diff = DIFF_W'(in_data.channel) + DIFF_W'(CHANNELS) - DIFF_W'(ptr_q);
		if (diff >= DIFF_W'(CHANNELS)) begin
			diff = diff - DIFF_W'(CHANNELS);
		end
		phys  = IDX_W'(diff);
		wr_ok = 32'(in_data.channel) < CHANNELS;

		rot_d   = rot_q;
		ptr_d   = ptr_q;
		sum_d   = sum_q;
		slot_d  = slot_q;
		ticks_d = ticks_q;
		start   = 1'b0;

		if (acc) begin
			unique case (in_data.action)
				ACT_TICK: begin
					if (load) begin
						slot_d  = nslot;
						ticks_d = cnt_load - COUNT_BITS'(1);
						start   = (nslot == '0);
						if (nslot < SLOT_W'(CHANNELS)) begin
							for (int k = 0; k < CHANNELS; k++) begin
								rot_d[k] = rot_q[(k + 1) % CHANNELS];
							end
							ptr_d = (ptr_q == IDX_W'(CHANNELS - 1)) ? '0 :
								ptr_q + IDX_W'(1);
						end
					end else begin
						ticks_d = ticks_q - COUNT_BITS'(1);
					end
				end
				ACT_WRITE_ONE: begin
					if (wr_ok) begin
						sum_d       = sum_q - SUM_W'(rot_q[phys]) +
							SUM_W'(in_data.pulse_width);
						rot_d[phys] = in_data.pulse_width;
					end
				end
				ACT_WRITE_ALL: begin
					for (int k = 0; k < CHANNELS; k++) begin
						rot_d[k] = in_data.pulse_width;
					end
					sum_d = SUM_W'(in_data.pulse_width) * SUM_W'(CHANNELS);
				end
				ACT_NONE: begin
				end
				default: begin
				end
			endcase
		end

		res.servo_pins  = (slot_d < SLOT_W'(CHANNELS)) ? (PINS_W'(1) << slot_d) : '0;
		res.frame_start = start;
		res.overrun     = sum_d >= SUM_W'(frame_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_q <= RESET_FRAME;
			for (int k = 0; k < CHANNELS; k++) begin
				rot_q[k] <= RESET_WIDTH;
			end
			ptr_q   <= '0;
			sum_q   <= SUM_W'(RESET_WIDTH) * SUM_W'(CHANNELS);
			slot_q  <= SLOT_W'(CHANNELS);
			ticks_q <= '0;
		end else begin
			if (cfg_valid) begin
				frame_q <= cfg_data;
			end
			rot_q   <= rot_d;
			ptr_q   <= ptr_d;
			sum_q   <= sum_d;
			slot_q  <= slot_d;
			ticks_q <= ticks_d;
		end
	end

	mcsps_skid u_skid (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (acc),
		.in_ready  (res_ready),
		.in_data   (res),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

endmodule

@@ hdl/mcsps_skid.sv @@
// ----------------------------------------------------------------------------
// mcsps_skid : two-entry result buffer
// Holds results so the sequencer can take a request while the sink stalls.
// ----------------------------------------------------------------------------
module mcsps_skid (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  mcsps_pkg::out_item_t in_data,
	output logic                 out_valid,
	input  logic                 out_ready,
	output mcsps_pkg::out_item_t out_data
);
	import mcsps_pkg::*;

	out_item_t main_q;
	out_item_t skid_q;
	logic      main_valid_q;
	logic      skid_valid_q;

	assign in_ready  = !skid_valid_q;
	assign out_valid = main_valid_q;
	assign out_data  = main_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			main_valid_q <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (out_ready || !main_valid_q) begin
			main_valid_q <= skid_valid_q || in_valid;
			skid_valid_q <= 1'b0;
		end else if (in_valid && !skid_valid_q) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (out_ready || !main_valid_q) begin
			main_q <= skid_valid_q ? skid_q : in_data;
		end else if (in_valid && !skid_valid_q) begin
			skid_q <= in_data;
		end
	end

endmodule

@@ hdl/mcsps_checker.sv @@
// ----------------------------------------------------------------------------
// mcsps_checker : port-level checks for the servo sequencer
// Watches the top-level ports; attached by bind below.
// ----------------------------------------------------------------------------
module mcsps_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          in_valid,
	input logic                          in_ready,
	input logic                          out_valid,
	input logic                          out_ready,
	input mcsps_pkg::out_item_t          out_data
);
	import mcsps_pkg::*;

	// request backpressure only with a result waiting
	a_ready_low: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> out_valid)
		else $error("in_ready low with no result pending");

	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> out_valid)
		else $error("accepted request produced no result");

	a_pins_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> $onehot0(out_data.servo_pins))
		else $error("more than one servo pin high");

	a_frame_start: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.frame_start |-> out_data.servo_pins == PINS_W'(1))
		else $error("frame start outside channel 0 slot");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("stalled result changed");

endmodule

bind multi_channel_servo_pulse_sequencer mcsps_checker u_mcsps_checker (.*);
